// ----- rtl/pit_pkg.sv -----
// shared types and constants for the point-in-triangle pipeline
package pit_pkg;

	// axis index of a 3-vector component
	typedef logic [1:0] axis_t;

	// component k of a x b is a[AX_A[k]]*b[AX_B[k]] - a[AX_B[k]]*b[AX_A[k]]
	localparam axis_t AX_A [3] = '{2'd1, 2'd2, 2'd0};
	localparam axis_t AX_B [3] = '{2'd2, 2'd0, 2'd1};

	// dot products formed against the normal
	localparam int unsigned DOT_D = 0;
	localparam int unsigned DOT_G = 1;
	localparam int unsigned DOT_B = 2;

	// sign and range results taken ahead of the final compare
	typedef struct packed {
		logic off;
		logic d_zero;
		logic g_neg;
		logic g_over;
		logic b_neg;
		logic b_over;
	} pit_flags_t;

endpackage

// ----- rtl/point_in_triangle_test_top.sv -----
// exact 3d point-in-triangle test: triangle corners a, b, c and point p in, one flag pair out
//
// Input channel: in_valid/in_ready with the twelve corner and point coordinates,
// each a signed COORD_WIDTH-bit fixed-point value. Output channel: out_valid/out_ready
// with inside_res (point in the triangle, edges and corners included) and off_plane
// (point not in the triangle's plane; inside_res is then 0). A degenerate triangle
// reports neither flag set... inside_res is 0 and off_plane follows the plane test.
// The pipeline has nine register stages. Throughput: one transfer per cycle while
// out_ready is high (a stalled receiver holds the flow up), since the
// block keeps no state between items. The stages are the corner differences, the cross
// product terms, the cross products, the split partial products, the middle-term sums,
// the full products, the dot sums, the sign and range compares and the final flags.
// Every stage has its own valid bit and advances when the stage after it is empty or
// moving, so bubbles close up while the receiver stalls; in_ready drops only once all
// nine stages hold items and out_ready is low. Nothing is lost or repeated in a stall.
// Reset clears the valid bits only; the pipeline comes out of reset empty.
module point_in_triangle_test_top
	import pit_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] c_z,
	input  logic signed [COORD_WIDTH-1:0] p_x,
	input  logic signed [COORD_WIDTH-1:0] p_y,
	input  logic signed [COORD_WIDTH-1:0] p_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          inside_res,
	output logic                          off_plane
);

	localparam int VW = COORD_WIDTH + 1;   // corner differences
	localparam int PW = 2 * VW;            // one cross product term
	localparam int NW = PW + 1;            // cross product component
	localparam int H  = (NW + 1) / 2;      // low split of a component
	localparam int HI = NW - H;            // high split of a component
	localparam int MW = HI + H + 2;        // sum of the two middle partial products
	localparam int FW = 2 * NW;            // full product of two components
	localparam int DW = FW + 3;            // dot sums and g + b
	localparam int XW = VW + NW;           // one term of w.n
	localparam int SW = XW + 2;            // w.n sum

	// stage advance chain
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	logic signed [COORD_WIDTH-1:0] a_in [3];
	logic signed [COORD_WIDTH-1:0] b_in [3];
	logic signed [COORD_WIDTH-1:0] c_in [3];
	logic signed [COORD_WIDTH-1:0] p_in [3];

	logic signed [VW-1:0] u_s1 [3];
	logic signed [VW-1:0] v_s1 [3];
	logic signed [VW-1:0] w_s1 [3];

	// [vector: n, u x w, w x v][component][term]
	logic signed [PW-1:0] xp_s2 [3][3][2];
	logic signed [VW-1:0] w_s2 [3];

	// [vector: n, u x w, w x v][component]
	logic signed [NW-1:0] xs_s3 [3][3];
	logic signed [VW-1:0] w_s3 [3];

	// [dot][component]
	logic signed [2*HI-1:0]   hh_s4 [3][3];
	logic signed [HI+H:0]     hl_s4 [3][3];
	logic signed [HI+H:0]     lh_s4 [3][3];
	logic        [2*H-1:0]    ll_s4 [3][3];
	logic signed [VW+HI-1:0]  wnh_s4 [3];
	logic signed [VW+H:0]     wnl_s4 [3];

	logic signed [FW-1:0] cat_s5 [3][3];
	logic signed [MW-1:0] mid_s5 [3][3];
	logic signed [XW-1:0] wnt_s5 [3];

	logic signed [FW-1:0] term_s6 [3][3];
	logic                 off_s6;
	logic                 off_s7;

	logic signed [DW-1:0] dot_s7 [3];

	logic signed [DW-1:0] d_s8;
	logic signed [DW-1:0] s_s8;
	pit_flags_t           flags_s8;

	logic                 inside_s9;
	logic                 off_s9;

	logic signed [SW-1:0] wn_sum;

	assign a_in = '{a_x, a_y, a_z};
	assign b_in = '{b_x, b_y, b_z};
	assign c_in = '{c_x, c_y, c_z};
	assign p_in = '{p_x, p_y, p_z};

	assign adv9 = !vld_s9 || out_ready;
	assign adv8 = !vld_s8 || adv9;
	assign adv7 = !vld_s7 || adv8;
	assign adv6 = !vld_s6 || adv7;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
			if (adv9) vld_s9 <= vld_s8;
		end
	end

	// stage 1: edges and point offset from corner a
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int k = 0; k < 3; k++) begin
				u_s1[k] <= VW'(b_in[k]) - VW'(a_in[k]);
				v_s1[k] <= VW'(c_in[k]) - VW'(a_in[k]);
				w_s1[k] <= VW'(p_in[k]) - VW'(a_in[k]);
			end
		end
	end

	// stage 2: the two terms of each cross product component
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int k = 0; k < 3; k++) begin
				xp_s2[DOT_D][k][0] <= u_s1[AX_A[k]] * v_s1[AX_B[k]];
				xp_s2[DOT_D][k][1] <= u_s1[AX_B[k]] * v_s1[AX_A[k]];
				xp_s2[DOT_G][k][0] <= u_s1[AX_A[k]] * w_s1[AX_B[k]];
				xp_s2[DOT_G][k][1] <= u_s1[AX_B[k]] * w_s1[AX_A[k]];
				xp_s2[DOT_B][k][0] <= w_s1[AX_A[k]] * v_s1[AX_B[k]];
				xp_s2[DOT_B][k][1] <= w_s1[AX_B[k]] * v_s1[AX_A[k]];
			end
			w_s2 <= w_s1;
		end
	end

	// stage 3: normal n = u x v, u x w and w x v
	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int m = 0; m < 3; m++) begin
				for (int k = 0; k < 3; k++) begin
					xs_s3[m][k] <= NW'(xp_s2[m][k][0]) - NW'(xp_s2[m][k][1]);
				end
			end
			w_s3 <= w_s2;
		end
	end

	// stage 4: split partial products against the normal
	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int m = 0; m < 3; m++) begin
				for (int k = 0; k < 3; k++) begin
					hh_s4[m][k] <= $signed(xs_s3[m][k][NW-1:H]) *
						$signed(xs_s3[DOT_D][k][NW-1:H]);
					hl_s4[m][k] <= $signed(xs_s3[m][k][NW-1:H]) *
						$signed({1'b0, xs_s3[DOT_D][k][H-1:0]});
					lh_s4[m][k] <= $signed({1'b0, xs_s3[m][k][H-1:0]}) *
						$signed(xs_s3[DOT_D][k][NW-1:H]);
					ll_s4[m][k] <= xs_s3[m][k][H-1:0] * xs_s3[DOT_D][k][H-1:0];
				end
			end
			for (int k = 0; k < 3; k++) begin
				wnh_s4[k] <= w_s3[k] * $signed(xs_s3[DOT_D][k][NW-1:H]);
				wnl_s4[k] <= w_s3[k] * $signed({1'b0, xs_s3[DOT_D][k][H-1:0]});
			end
		end
	end

	// stage 5: high and low parts side by side, middle parts summed
	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int m = 0; m < 3; m++) begin
				for (int k = 0; k < 3; k++) begin
					cat_s5[m][k] <= {hh_s4[m][k], ll_s4[m][k]};
					mid_s5[m][k] <= MW'(hl_s4[m][k]) + MW'(lh_s4[m][k]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				wnt_s5[k] <= (XW'(wnh_s4[k]) <<< H) + XW'(wnl_s4[k]);
			end
		end
	end

	assign wn_sum = SW'(wnt_s5[0]) + SW'(wnt_s5[1]) + SW'(wnt_s5[2]);

	// stage 6: full products; plane test on w.n
	always_ff @(posedge clk) begin
		if (adv6) begin
			for (int m = 0; m < 3; m++) begin
				for (int k = 0; k < 3; k++) begin
					term_s6[m][k] <= cat_s5[m][k] + (FW'(mid_s5[m][k]) <<< H);
				end
			end
			off_s6 <= (wn_sum != '0);
		end
	end

	// stage 7: dot products n.n, (u x w).n and (w x v).n
	always_ff @(posedge clk) begin
		if (adv7) begin
			for (int m = 0; m < 3; m++) begin
				dot_s7[m] <= DW'(term_s6[m][0]) + DW'(term_s6[m][1]) + DW'(term_s6[m][2]);
			end
			off_s7 <= off_s6;
		end
	end

	// stage 8: weight sign and range checks against n.n, plus the n.n zero test and g + b
	always_ff @(posedge clk) begin
		if (adv8) begin
			d_s8            <= dot_s7[DOT_D];
			s_s8            <= dot_s7[DOT_G] + dot_s7[DOT_B];
			flags_s8.off    <= off_s7;
			flags_s8.d_zero <= (dot_s7[DOT_D] == '0);
			flags_s8.g_neg  <= dot_s7[DOT_G][DW-1];
			flags_s8.g_over <= (dot_s7[DOT_G] > dot_s7[DOT_D]);
			flags_s8.b_neg  <= dot_s7[DOT_B][DW-1];
			flags_s8.b_over <= (dot_s7[DOT_B] > dot_s7[DOT_D]);
		end
	end

	// stage 9: output register
	always_ff @(posedge clk) begin
		if (adv9) begin
			off_s9    <= flags_s8.off;
			inside_s9 <= !flags_s8.off && !flags_s8.d_zero &&
				!flags_s8.g_neg && !flags_s8.g_over &&
				!flags_s8.b_neg && !flags_s8.b_over &&
				!s_s8[DW-1] && !(s_s8 > d_s8);
		end
	end

	assign out_valid  = vld_s9;
	assign inside_res = inside_s9;
	assign off_plane  = off_s9;

	// a point off the plane is never reported inside
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(inside_res && off_plane))
		else $error("inside and off_plane both set");

	// input back-pressure only when every stage holds an item and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 &&
			vld_s6 && vld_s7 && vld_s8 && vld_s9 && !out_ready))
		else $error("in_ready low with room in the pipeline");

	// a degenerate triangle comes out as outside
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv9 && vld_s8 && flags_s8.d_zero) |=> (out_valid && !inside_res))
		else $error("degenerate triangle reported inside");

	// a stalled output item is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(inside_res) &&
			$stable(off_plane)))
		else $error("stalled result changed");

endmodule

// ----- tb/sv/point_in_triangle_test_top_test.sv -----
// testbench for point_in_triangle_test_top: directed, planar-lattice and noise queries
module point_in_triangle_test_top_test;

	localparam int CW = 16;
	localparam int CMIN = -(1 << (CW - 1));
	localparam int CMAX = (1 << (CW - 1)) - 1;
	localparam int RANDOM_QUERIES = 2000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		coord_t a[3];
		coord_t b[3];
		coord_t c[3];
		coord_t p[3];
	} tri_query_t;

	typedef struct packed {
		logic in_tri;
		logic off_pl;
	} verdict_t;

	typedef enum {RX_FREE, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

	class triangle_verdicts;
		verdict_t pending[$];
		int unsigned faults = 0;

		function void cross_prod(input longint x[3], input longint y[3], output longint r[3]);
			r[0] = x[1] * y[2] - x[2] * y[1];
			r[1] = x[2] * y[0] - x[0] * y[2];
			r[2] = x[0] * y[1] - x[1] * y[0];
		endfunction

		function wide_t dot_prod(input longint x[3], input longint y[3]);
			return wide_t'(x[0]) * wide_t'(y[0]) + wide_t'(x[1]) * wide_t'(y[1])
				+ wide_t'(x[2]) * wide_t'(y[2]);
		endfunction

		function verdict_t classify_point(tri_query_t q);
			longint u[3], v[3], w[3], nrm[3], uw[3], wv[3];
			wide_t nn, gam, bet, s;
			verdict_t vd;
			int k;
			for (k = 0; k < 3; k++) begin
				u[k] = longint'(q.b[k]) - longint'(q.a[k]);
				v[k] = longint'(q.c[k]) - longint'(q.a[k]);
				w[k] = longint'(q.p[k]) - longint'(q.a[k]);
			end
			cross_prod(u, v, nrm);
			cross_prod(u, w, uw);
			cross_prod(w, v, wv);
			nn = dot_prod(nrm, nrm);
			gam = dot_prod(uw, nrm);
			bet = dot_prod(wv, nrm);
			s = gam + bet;
			vd.off_pl = dot_prod(w, nrm) != 0;
			// weights compared against n.n instead of dividing, boundaries inclusive
			vd.in_tri = !vd.off_pl && nn != 0 && gam >= 0 && gam <= nn
				&& bet >= 0 && bet <= nn && s >= 0 && s <= nn;
			return vd;
		endfunction

		function void note_query(tri_query_t q);
			pending = {pending, classify_point(q)};
		endfunction

		function void check_verdict(logic in_tri, logic off_pl);
			verdict_t exp_v;
			if (pending.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result inside_res=%b off_plane=%b", in_tri, off_pl);
				return;
			end
			exp_v = pending.pop_front();
			if (exp_v.in_tri !== in_tri || exp_v.off_pl !== off_pl) begin
				faults++;
				if (faults <= 10)
					$display("mismatch: expected inside_res=%b off_plane=%b, got %b %b",
						exp_v.in_tri, exp_v.off_pl, in_tri, off_pl);
			end
		endfunction

		function int unsigned outstanding();
			return pending.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid, inside_res, off_plane;
	coord_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
	coord_t c_x = '0, c_y = '0, c_z = '0, p_x = '0, p_y = '0, p_z = '0;

	triangle_verdicts verdicts = new();
	int unsigned queries_taken = 0;

	point_in_triangle_test_top #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z), .p_x(p_x), .p_y(p_y), .p_z(p_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.inside_res(inside_res), .off_plane(off_plane)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("[point_in_triangle_test_top] ERROR");
		$finish;
	end

	// both channels sampled at the edge, before any driver update lands
	always @(posedge clk) begin
		tri_query_t q;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				q.a = '{a_x, a_y, a_z};
				q.b = '{b_x, b_y, b_z};
				q.c = '{c_x, c_y, c_z};
				q.p = '{p_x, p_y, p_z};
				verdicts.note_query(q);
				queries_taken <= queries_taken + 1;
			end
			if (out_valid && out_ready)
				verdicts.check_verdict(inside_res, off_plane);
		end
	end

	function automatic tri_query_t tq(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz, int px, int py, int pz);
		tri_query_t q;
		q.a = '{coord_t'(ax), coord_t'(ay), coord_t'(az)};
		q.b = '{coord_t'(bx), coord_t'(by), coord_t'(bz)};
		q.c = '{coord_t'(cx), coord_t'(cy), coord_t'(cz)};
		q.p = '{coord_t'(px), coord_t'(py), coord_t'(pz)};
		return q;
	endfunction

	// p = a + i*d1 + j*d2 on an integer lattice, in the plane unless nudge moves p
	function automatic tri_query_t make_planar(bit collapse, bit nudge);
		tri_query_t q;
		int d1[3], d2[3], offs[3];
		int span, k, i, j, m, lo, hi, base, ax, o;
		bit fits;
		do begin
			span = 1 << $urandom_range(0, 11);
			k = $urandom_range(1, 8);
			m = int'($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 1)) begin
				i = $urandom_range(0, k);
				j = $urandom_range(0, k - i);
			end else begin
				i = int'($urandom_range(0, 3 * k)) - k;
				j = int'($urandom_range(0, 3 * k)) - k;
			end
			fits = 1'b1;
			for (ax = 0; ax < 3; ax++) begin
				d1[ax] = int'($urandom_range(0, 2 * span)) - span;
				d2[ax] = collapse ? m * d1[ax] : int'($urandom_range(0, 2 * span)) - span;
				offs = '{k * d1[ax], k * d2[ax], i * d1[ax] + j * d2[ax]};
				lo = CMIN;
				hi = CMAX;
				for (o = 0; o < 3; o++) begin
					if (offs[o] < 0)
						lo -= offs[o];
					else
						hi -= offs[o];
				end
				if (lo > hi) begin
					fits = 1'b0;
				end else begin
					case ($urandom_range(0, 5))
						0: base = lo;
						1: base = hi;
						default: base = lo + int'($urandom_range(0, hi - lo));
					endcase
					q.a[ax] = coord_t'(base);
					q.b[ax] = coord_t'(base + offs[0]);
					q.c[ax] = coord_t'(base + offs[1]);
					q.p[ax] = coord_t'(base + offs[2]);
				end
			end
		end while (!fits);
		if (nudge) begin
			ax = $urandom_range(0, 2);
			if (q.p[ax] == coord_t'(CMAX))
				q.p[ax] = coord_t'(q.p[ax] - 1);
			else
				q.p[ax] = coord_t'(q.p[ax] + 1);
		end
		return q;
	endfunction

	function automatic tri_query_t random_query();
		tri_query_t q;
		int r, ax;
		r = $urandom_range(0, 99);
		if (r < 55)
			return make_planar(1'b0, 1'b0);
		if (r < 65)
			return make_planar(1'b1, 1'b0);
		if (r < 80)
			return make_planar(1'b0, 1'b1);
		for (ax = 0; ax < 3; ax++) begin
			q.a[ax] = coord_t'($urandom);
			q.b[ax] = coord_t'($urandom);
			q.c[ax] = coord_t'($urandom);
			q.p[ax] = coord_t'($urandom);
		end
		return q;
	endfunction

	task automatic send_query(input tri_query_t q);
		a_x <= q.a[0]; a_y <= q.a[1]; a_z <= q.a[2];
		b_x <= q.b[0]; b_y <= q.b[1]; b_z <= q.b[2];
		c_x <= q.c[0]; c_y <= q.c[1]; c_z <= q.c[2];
		p_x <= q.p[0]; p_y <= q.p[1]; p_z <= q.p[2];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (verdicts.outstanding() != 0);
	endtask

	// receiver: stall pattern of its own, plus one long hold-off to back up the pipeline
	initial begin
		rx_mode_e mode;
		int seg, phase;
		bit held;
		held = 1'b0;
		phase = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held && queries_taken >= 400) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (150) @(posedge clk);
			end
			mode = rx_mode_e'($urandom_range(0, 3));
			seg = $urandom_range(10, 100);
			repeat (seg) begin
				case (mode)
					RX_FREE: out_ready <= 1'b1;
					RX_COIN: out_ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: out_ready <= (phase % 3) != 0;
					RX_SPARSE: out_ready <= $urandom_range(0, 4) == 0;
					default: out_ready <= 1'b1;
				endcase
				phase++;
				@(posedge clk);
			end
		end
	end

	initial begin
		int sent, burst;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// degenerate: every corner the same
		send_query(tq(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(tq(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
		send_query(tq(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		// small right triangle: interior, corners, edges, outside, off the plane
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 0, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 4, 0, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 4, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 2, 2, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 2, 0, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 2, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 5, 0, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 3, 3, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, -1, 0, 0));
		send_query(tq(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 1));
		// full-range triangle in z=0
		send_query(tq(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, 0, 0, 0));
		send_query(tq(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, CMIN, CMIN, 0));
		send_query(tq(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, CMAX, CMAX, 0));
		send_query(tq(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, CMIN, CMIN, CMIN));
		// largest products and sums
		send_query(tq(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN));
		send_query(tq(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN));
		// collinear and coincident corners
		send_query(tq(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1));
		send_query(tq(0, 0, 0, 1, 1, 1, 2, 2, 2, 5, -3, 7));
		send_query(tq(100, 200, 300, -5, 6, 7, -5, 6, 7, 100, 200, 300));

		sent = 0;
		burst = 0;
		while (sent < RANDOM_QUERIES) begin
			if (sent == RANDOM_QUERIES / 2)
				drain_results();
			if (burst == 0) begin
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
				idle_input($urandom_range(1, 12));
			end
			send_query(random_query());
			sent++;
			burst--;
		end
		drain_results();
		repeat (16) @(posedge clk);
		if (verdicts.faults == 0 && verdicts.outstanding() == 0)
			$display("[point_in_triangle_test_top] OK");
		else
			$display("[point_in_triangle_test_top] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/pit_pkg.sv
rtl/point_in_triangle_test_top.sv
tb/sv/point_in_triangle_test_top_test.sv
